FILE: design/csvft_pkg.sv
// csv field tokenizer package: parser state codes, byte classes, result type and step table
package csvft_pkg;

  localparam int FNUM_W = 16;
  localparam int RNUM_W = 32;

  localparam logic [3:0] ST_LF     = 4'd0;
  localparam logic [3:0] ST_CR     = 4'd1;
  localparam logic [3:0] ST_CRLF   = 4'd2;
  localparam logic [3:0] ST_COMMA  = 4'd3;
  localparam logic [3:0] ST_PLAIN  = 4'd4;
  localparam logic [3:0] ST_QUOTED = 4'd5;
  localparam logic [3:0] ST_OPENQ  = 4'd6;
  localparam logic [3:0] ST_QINQ   = 4'd7;
  localparam logic [3:0] ST_ERR    = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;

  localparam logic [2:0] K_NUL   = 3'd0;
  localparam logic [2:0] K_COMMA = 3'd1;
  localparam logic [2:0] K_QUOTE = 3'd2;
  localparam logic [2:0] K_LF    = 3'd3;
  localparam logic [2:0] K_CR    = 3'd4;
  localparam logic [2:0] K_OTHER = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_ERR = 2'd1;
  localparam logic [1:0] STAT_FIN = 2'd2;

  typedef struct packed {
    logic              char_valid;
    logic [7:0]        char_out;
    logic              field_end;
    logic              record_end;
    logic [FNUM_W-1:0] field_number;
    logic [RNUM_W-1:0] record_number;
    logic [1:0]        status;
  } res_t;

  function automatic logic [2:0] byte_kind(input logic [7:0] c);
    logic [2:0] k;
    unique case (c)
      CH_NUL:   k = K_NUL;
      CH_COMMA: k = K_COMMA;
      CH_QUOTE: k = K_QUOTE;
      CH_LF:    k = K_LF;
      CH_CR:    k = K_CR;
      default:  k = K_OTHER;
    endcase
    return k;
  endfunction

  // s is one of the eight table states
  function automatic logic [3:0] next_state(input logic [3:0] s, input logic [2:0] k);
    logic [3:0] n;
    logic       qrow;
    qrow = (s == ST_QUOTED) || (s == ST_OPENQ);
    unique case (k)
      K_NUL:   n = ST_ERR;
      K_COMMA: n = qrow ? ST_QUOTED : ST_COMMA;
      K_QUOTE: begin
        case (s) inside
          ST_PLAIN:            n = ST_ERR;
          ST_QUOTED, ST_OPENQ: n = ST_QINQ;
          ST_QINQ:             n = ST_QUOTED;
          default:             n = ST_OPENQ;
        endcase
      end
      K_LF:    n = qrow ? ST_QUOTED : ((s == ST_CR) ? ST_CRLF : ST_LF);
      K_CR:    n = qrow ? ST_QUOTED : ST_CR;
      default: n = qrow ? ST_QUOTED : ((s == ST_QINQ) ? ST_ERR : ST_PLAIN);
    endcase
    return n;
  endfunction

endpackage

FILE: design/csv_field_tokenizer.sv
// csv field tokenizer top level: byte classing, parser state, counters and output skid stage
//
// input stream s_*: one word per byte; s_tdata[7:0] is data_byte and s_tuser[0] is action
// (0 data byte, 1 finish request). output stream m_*: exactly one result word per input word.
// m_tuser[0] is char_valid, m_tlast is record_end, and m_tdata carries the other fields.
// each accepted word is classed, the parser table is stepped and the field and record
// counters are updated in the same cycle; the result is registered in the output register,
// or in the skid register while the receiver stalls, before it appears on m_*. throughput is
// one word per cycle while the receiver takes results, set by the state and counter update loop.
// the output register is backed by a one-word skid register: when the receiver stalls,
// one more word is taken and held, then s_tready drops until m_tready frees a slot.
// results leave in acceptance order.
// rst (synchronous, active high) empties both output slots and returns the parser to the
// start-of-record state with field and record numbers at 1.
// parse errors are sticky until reset; a finish between fields reports status 2 and any
// item after that reports a parse error.
module csv_field_tokenizer
  import csvft_pkg::*;
#(
  parameter int FIELD_COUNT_BITS  = 16,
  parameter int RECORD_COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // data_byte[7:0]
  input  logic [0:0]  s_tuser,  // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // char_out[7:0] field_end[8] field_number[24:9]
                                // record_number[56:25] status[58:57] zero[63:59]
  output logic [0:0]  m_tuser,  // char_valid[0]
  output logic        m_tlast
);

  logic [3:0]                   state;
  logic [3:0]                   state_next;
  logic [FIELD_COUNT_BITS-1:0]  field_count;
  logic [FIELD_COUNT_BITS-1:0]  field_count_next;
  logic [RECORD_COUNT_BITS-1:0] record_count;
  logic [RECORD_COUNT_BITS-1:0] record_count_next;

  res_t res_next;
  res_t out_res;
  res_t skid_res;
  logic out_valid;
  logic skid_valid;

  logic s_acc;
  logic m_acc;
  logic fc_over;
  logic rc_over;

  assign s_tready = !skid_valid;
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = out_valid && m_tready;

  if (FIELD_COUNT_BITS > FNUM_W) begin : g_fc_sat
    assign fc_over = |field_count[FIELD_COUNT_BITS-1:FNUM_W];
  end else begin : g_fc_fit
    assign fc_over = 1'b0;
  end

  if (RECORD_COUNT_BITS > RNUM_W) begin : g_rc_sat
    assign rc_over = |record_count[RECORD_COUNT_BITS-1:RNUM_W];
  end else begin : g_rc_fit
    assign rc_over = 1'b0;
  end

  always_comb begin
    state_next        = state;
    field_count_next  = field_count;
    record_count_next = record_count;
    res_next          = '0;
    res_next.field_number  = fc_over ? {FNUM_W{1'b1}} : FNUM_W'(field_count);
    res_next.record_number = rc_over ? {RNUM_W{1'b1}} : RNUM_W'(record_count);
    if (state[3]) begin
      state_next = ST_ERR;
    end else if (s_tuser[0]) begin
      state_next = (state <= ST_COMMA) ? ST_FIN : ST_ERR;
    end else begin
      state_next = next_state(state, byte_kind(s_tdata));
      case (state_next) inside
        ST_PLAIN, ST_QUOTED: begin
          res_next.char_valid = 1'b1;
          res_next.char_out   = s_tdata;
        end
        ST_COMMA: begin
          res_next.field_end = 1'b1;
          if (!(&field_count)) begin
            field_count_next = field_count + 1'b1;
          end
        end
        ST_LF, ST_CR: begin
          res_next.field_end  = 1'b1;
          res_next.record_end = 1'b1;
          field_count_next    = FIELD_COUNT_BITS'(1);
          if (!(&record_count)) begin
            record_count_next = record_count + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (state_next == ST_ERR) begin
      res_next.status = STAT_ERR;
    end else if (state_next == ST_FIN) begin
      res_next.status = STAT_FIN;
    end else begin
      res_next.status = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LF;
      field_count  <= FIELD_COUNT_BITS'(1);
      record_count <= RECORD_COUNT_BITS'(1);
    end else if (s_acc) begin
      state        <= state_next;
      field_count  <= field_count_next;
      record_count <= record_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_acc) begin
        out_valid  <= skid_valid || s_acc;
        skid_valid <= 1'b0;
      end else if (s_acc) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_acc) begin
      out_res <= skid_valid ? skid_res : res_next;
    end
    if (s_acc && out_valid && !m_acc) begin
      skid_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.char_valid;
  assign m_tlast  = out_res.record_end;
  assign m_tdata  = {5'b0, out_res.status, out_res.record_number, out_res.field_number,
                     out_res.field_end, out_res.char_out};

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    state == ST_ERR |=> state == ST_ERR)
    else $error("parser left the error state");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held while output slot empty");

  a_rec_end_closes_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.record_end |-> out_res.field_end && !out_res.char_valid)
    else $error("record end without field end");

  a_field_reset: assert property (@(posedge clk) disable iff (rst)
    s_acc && (state_next == ST_LF || state_next == ST_CR) && !state[3] && !s_tuser[0]
    |=> field_count == FIELD_COUNT_BITS'(1))
    else $error("field count not restarted at record end");

  a_char_only_in_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.char_valid |-> !out_res.field_end && out_res.status == STAT_OK)
    else $error("content byte with field end or bad status");
`endif

endmodule
